// ===== sv/bda_pkg.sv =====
`default_nettype none
package bda_pkg;

    localparam int FIELD_BITS = 8;
    localparam int NUM_FIELDS = 4;

    // function codes
    localparam logic [1:0] FUNC_LOAD_MAX   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_REQUEST    = 2'd2;
    localparam logic [1:0] FUNC_CHECK      = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXCEEDS  = 3'd1;
    localparam logic [2:0] ST_WAIT     = 3'd2;
    localparam logic [2:0] ST_ROLLBACK = 3'd3;
    localparam logic [2:0] ST_UNSAFE   = 3'd4;
    localparam logic [2:0] ST_REFUSED  = 3'd5;

    // datapath commands
    typedef struct packed {
        logic latch_item;   // capture item, set entry pointer to item process
        logic read_entry;   // register table row at pointer
        logic init_check;   // work = total - sum, clear finish flags, scan pointer and progress mark
        logic scan_step;    // test entry at pointer and finish it if it fits
        logic scan_next;    // advance scan pointer, clear on wrap
        logic write_max;
        logic write_alloc;
        logic grant;        // add amounts to allocation
        logic rollback;     // subtract amounts from allocation
    } t_dp_cmd;

    // datapath status
    typedef struct packed {
        logic proc_bad;
        logic below_alloc;
        logic above_max;
        logic above_need;
        logic over_alloc;
        logic above_free;
        logic scan_last;
        logic progress;
        logic all_done;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== sv/bda_datapath.sv =====
`default_nettype none
module bda_datapath
    import bda_pkg::*;
#(
    parameter int NUM_PROCS  = 8,
    parameter int NUM_TYPES  = 4,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_idx,
    input  wire logic [7:0]            i_cfg_data,
    input  wire logic [2:0]            i_process,
    input  wire logic [7:0]            i_amount0,
    input  wire logic [7:0]            i_amount1,
    input  wire logic [7:0]            i_amount2,
    input  wire logic [7:0]            i_amount3,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat
);
    localparam int PB = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int SB = COUNT_BITS + PB;

    logic [COUNT_BITS-1:0] r_total [NUM_TYPES];
    logic [COUNT_BITS-1:0] r_max   [NUM_PROCS][NUM_TYPES];
    logic [COUNT_BITS-1:0] r_alloc [NUM_PROCS][NUM_TYPES];
    logic [SB-1:0]         r_sum   [NUM_TYPES];
    logic [SB:0]           r_work  [NUM_TYPES];
    logic [NUM_PROCS-1:0]  r_fin;
    logic [COUNT_BITS-1:0] r_amt   [NUM_TYPES];
    logic [COUNT_BITS-1:0] r_emax  [NUM_TYPES];
    logic [COUNT_BITS-1:0] r_ealloc[NUM_TYPES];
    logic [PB-1:0]         r_ptr;
    logic [PB-1:0]         r_pidx;
    logic                  r_bad;
    logic                  r_prog;

    logic [7:0]            w_in [NUM_FIELDS];
    logic [NUM_TYPES-1:0]  w_lt, w_gt, w_need, w_over, w_free, w_fit;
    logic                  w_take;

    assign w_in[0] = i_amount0;
    assign w_in[1] = i_amount1;
    assign w_in[2] = i_amount2;
    assign w_in[3] = i_amount3;

    // per-type compares on the registered row
    always_comb begin
        for (int t = 0; t < NUM_TYPES; t++) begin
            w_lt[t]   = r_amt[t] < r_ealloc[t];
            w_gt[t]   = r_amt[t] > r_emax[t];
            w_need[t] = {1'b0, r_amt[t]} >
                        ({1'b0, r_emax[t]} - {1'b0, r_ealloc[t]});
            w_over[t] = r_sum[t] > SB'(r_total[t]);
            w_free[t] = {{(SB-COUNT_BITS+1){1'b0}}, r_amt[t]} >
                        ({1'b0, SB'(r_total[t])} - {1'b0, r_sum[t]});
            w_fit[t]  = (SB+1)'(r_emax[t] - r_ealloc[t]) <= r_work[t];
        end
    end

    // entry under the scan pointer finishes now
    assign w_take = !r_fin[r_ptr] && (&w_fit);

    assign o_stat.proc_bad    = r_bad;
    assign o_stat.below_alloc = |w_lt;
    assign o_stat.above_max   = |w_gt;
    assign o_stat.above_need  = |w_need;
    assign o_stat.over_alloc  = |w_over;
    assign o_stat.above_free  = |w_free;
    assign o_stat.scan_last   = (32'(r_ptr) == NUM_PROCS - 1);
    assign o_stat.progress    = r_prog || w_take;
    assign o_stat.all_done    = &r_fin;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TYPES; t++) r_total[t] <= '0;
        end else if (i_cfg_we) begin
            for (int t = 0; t < NUM_TYPES; t++)
                if (t < NUM_FIELDS && 32'(i_cfg_idx) == t)
                    r_total[t] <= COUNT_BITS'(i_cfg_data & 8'((1 << COUNT_BITS) - 1));
        end
    end

    // tables, sums, scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PROCS; p++)
                for (int t = 0; t < NUM_TYPES; t++) begin
                    r_max[p][t]   <= '0;
                    r_alloc[p][t] <= '0;
                end
            for (int t = 0; t < NUM_TYPES; t++) begin
                r_sum[t]  <= '0;
                r_work[t] <= '0;
            end
            r_fin  <= '0;
            r_ptr  <= '0;
            r_pidx <= '0;
            r_bad  <= 1'b0;
            r_prog <= 1'b0;
        end else begin
            if (i_cmd.latch_item) begin
                for (int t = 0; t < NUM_TYPES; t++)
                    r_amt[t] <= (t < NUM_FIELDS) ? COUNT_BITS'(w_in[t]) : '0;
                r_bad  <= 32'(i_process) >= NUM_PROCS;
                r_ptr  <= PB'(i_process);
                r_pidx <= PB'(i_process);
            end
            if (i_cmd.read_entry) begin
                for (int t = 0; t < NUM_TYPES; t++) begin
                    r_emax[t]   <= r_max[r_ptr][t];
                    r_ealloc[t] <= r_alloc[r_ptr][t];
                end
            end
            if (i_cmd.init_check) begin
                for (int t = 0; t < NUM_TYPES; t++)
                    r_work[t] <= {1'b0, SB'(r_total[t])} - {1'b0, r_sum[t]};
                r_fin  <= '0;
                r_ptr  <= '0;
                r_prog <= 1'b0;
            end
            if (i_cmd.scan_step && w_take) begin
                r_fin[r_ptr] <= 1'b1;
                if (!(i_cmd.scan_next && o_stat.scan_last))
                    r_prog <= 1'b1;
                for (int t = 0; t < NUM_TYPES; t++)
                    r_work[t] <= r_work[t] + (SB+1)'(r_ealloc[t]);
            end
            if (i_cmd.scan_next) begin
                if (o_stat.scan_last) begin
                    r_ptr  <= '0;
                    r_prog <= 1'b0;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (i_cmd.write_max)
                for (int t = 0; t < NUM_TYPES; t++) r_max[r_pidx][t] <= r_amt[t];
            if (i_cmd.write_alloc)
                for (int t = 0; t < NUM_TYPES; t++) begin
                    r_alloc[r_pidx][t] <= r_amt[t];
                    r_sum[t] <= r_sum[t] - SB'(r_ealloc[t]) + SB'(r_amt[t]);
                end
            if (i_cmd.grant)
                for (int t = 0; t < NUM_TYPES; t++) begin
                    r_alloc[r_pidx][t] <= r_alloc[r_pidx][t] + r_amt[t];
                    r_sum[t] <= r_sum[t] + SB'(r_amt[t]);
                end
            if (i_cmd.rollback)
                for (int t = 0; t < NUM_TYPES; t++) begin
                    r_alloc[r_pidx][t] <= r_alloc[r_pidx][t] - r_amt[t];
                    r_sum[t] <= r_sum[t] - SB'(r_amt[t]);
                end
        end
    end

    // a finish inside a pass marks that pass as having made progress
    a_fin_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && w_take && !o_stat.scan_last) |=> r_prog)
        else $error("finish without progress mark");
    a_init_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.init_check |=> (r_fin == '0 && r_ptr == '0))
        else $error("check init did not clear scan state");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.write_max, i_cmd.write_alloc, i_cmd.grant, i_cmd.rollback}))
        else $error("conflicting table writes");
endmodule
`default_nettype wire

// ===== sv/bda_ctrl.sv =====
`default_nettype none
module bda_ctrl
    import bda_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [1:0] i_func,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd,
    output logic            busy,
    output logic            o_valid,
    output logic [2:0]      o_status
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_DEC   = 8'b0000_0100,
        S_GRANT = 8'b0000_1000,
        S_INIT  = 8'b0001_0000,
        S_FETCH = 8'b0010_0000,
        S_TEST  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_func;
    logic       r_req;
    logic       r_out_v, n_out_v;
    logic [2:0] r_out_st, n_out_st;
    logic       n_req;

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_v;
    assign o_status = r_out_st;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_out_v  = 1'b0;
        n_out_st = r_out_st;
        n_req    = r_req;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch_item = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_entry = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_IDLE;
                n_out_v = 1'b1;
                n_req   = 1'b0;
                if (r_func == FUNC_CHECK) begin
                    if (i_stat.over_alloc) n_out_st = ST_UNSAFE;
                    else begin
                        n_out_v = 1'b0;
                        n_state = S_INIT;
                    end
                end else if (i_stat.proc_bad) n_out_st = ST_REFUSED;
                else if (r_func == FUNC_LOAD_MAX) begin
                    if (i_stat.below_alloc) n_out_st = ST_REFUSED;
                    else begin
                        o_cmd.write_max = 1'b1;
                        n_out_st = ST_OK;
                    end
                end else if (r_func == FUNC_LOAD_ALLOC) begin
                    if (i_stat.above_max) n_out_st = ST_REFUSED;
                    else begin
                        o_cmd.write_alloc = 1'b1;
                        n_out_st = ST_OK;
                    end
                end else begin
                    if (i_stat.above_need)      n_out_st = ST_EXCEEDS;
                    else if (i_stat.over_alloc) n_out_st = ST_UNSAFE;
                    else if (i_stat.above_free) n_out_st = ST_WAIT;
                    else begin
                        n_out_v = 1'b0;
                        n_req   = 1'b1;
                        n_state = S_GRANT;
                    end
                end
            end
            S_GRANT: begin
                o_cmd.grant = 1'b1;
                n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_check = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.read_entry = 1'b1;
                n_state = S_TEST;
            end
            S_TEST: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.scan_next = 1'b1;
                n_state = S_FETCH;
                // end of a pass that finished nothing new
                if (i_stat.scan_last && !i_stat.progress) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
                n_out_v = 1'b1;
                if (i_stat.all_done) n_out_st = ST_OK;
                else if (r_req) begin
                    n_out_st = ST_ROLLBACK;
                    o_cmd.rollback = 1'b1;
                end else n_out_st = ST_UNSAFE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_req   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            r_req   <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_st <= n_out_st;
        if (r_state == S_IDLE && start) r_func <= i_func;
    end

    a_rollback_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rollback |-> r_req)
        else $error("rollback without grant");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> $past(r_state == S_DEC || r_state == S_DONE))
        else $error("result strobe outside decision");
    a_grant_then_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.grant |=> o_cmd.init_check)
        else $error("grant not followed by check");
endmodule
`default_nettype wire

// ===== sv/bankers_deadlock_avoidance.sv =====
`default_nettype none
// Banker's algorithm resource manager. Pulse start while busy is low to issue
// a load, request or safety check; exactly one o_valid pulse with o_status
// follows and the receiver cannot stall it. Loads, and requests that fail a
// test, are answered right after their table row is read and tested. A safety
// check with no type over-allocated, or a request that passes into one, scans
// the process table one entry at a time, fetching each row and then testing
// it, and repeats passes until one finishes nothing; the single shared compare
// unit tests one table row at a time.
module bankers_deadlock_avoidance
    import bda_pkg::*;
#(
    parameter int NUM_PROCS  = 8,
    parameter int NUM_TYPES  = 4,
    parameter int COUNT_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_func,
    input  wire logic [2:0] i_process,
    input  wire logic [7:0] i_amount0,
    input  wire logic [7:0] i_amount1,
    input  wire logic [7:0] i_amount2,
    input  wire logic [7:0] i_amount3,
    output logic            o_valid,
    output logic [2:0]      o_status
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    bda_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_func(i_func),
        .i_stat(w_stat), .o_cmd(w_cmd), .busy(busy), .o_valid(o_valid),
        .o_status(o_status)
    );

    bda_datapath #(
        .NUM_PROCS(NUM_PROCS), .NUM_TYPES(NUM_TYPES), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_idx(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_process(i_process),
        .i_amount0(i_amount0), .i_amount1(i_amount1),
        .i_amount2(i_amount2), .i_amount3(i_amount3),
        .i_cmd(w_cmd), .o_stat(w_stat)
    );
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
    import bda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 8;
    localparam int NTYPE = 4;
    localparam int CYCLE_LIMIT = 2000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_func = '0;
    logic [2:0] i_process = '0;
    logic [7:0] i_amount0 = '0;
    logic [7:0] i_amount1 = '0;
    logic [7:0] i_amount2 = '0;
    logic [7:0] i_amount3 = '0;
    logic       o_valid;
    logic [2:0] o_status;

    bankers_deadlock_avoidance dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy),
        .i_func(i_func), .i_process(i_process),
        .i_amount0(i_amount0), .i_amount1(i_amount1),
        .i_amount2(i_amount2), .i_amount3(i_amount3),
        .o_valid(o_valid), .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the allocator state
    logic [7:0]  total_units [NTYPE];
    logic [7:0]  claim_tab   [NPROC][NTYPE];
    logic [7:0]  held_tab    [NPROC][NTYPE];
    logic [10:0] held_sum    [NTYPE];

    logic [2:0] status_queue [$];
    int mismatches = 0;
    int cycles = 0;

    // true when any type is allocated beyond its total
    function automatic bit overcommitted();
        for (int t = 0; t < NTYPE; t++)
            if (held_sum[t] > {3'b0, total_units[t]}) return 1'b1;
        return 1'b0;
    endfunction

    // repeated scans: finish every process whose need fits the free pool
    function automatic bit state_is_safe();
        logic [10:0] pool [NTYPE];
        bit done [NPROC];
        bit moved;
        bit fits;
        for (int t = 0; t < NTYPE; t++) pool[t] = {3'b0, total_units[t]} - held_sum[t];
        for (int p = 0; p < NPROC; p++) done[p] = 1'b0;
        moved = 1'b1;
        while (moved) begin
            moved = 1'b0;
            for (int p = 0; p < NPROC; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int t = 0; t < NTYPE; t++)
                        if ({3'b0, claim_tab[p][t] - held_tab[p][t]} > pool[t]) fits = 1'b0;
                    if (fits) begin
                        done[p] = 1'b1;
                        for (int t = 0; t < NTYPE; t++) pool[t] += held_tab[p][t];
                        moved = 1'b1;
                    end
                end
            end
        end
        for (int p = 0; p < NPROC; p++)
            if (!done[p]) return 1'b0;
        return 1'b1;
    endfunction

    // expected status of one command, updating the shadow state
    function automatic logic [2:0] allocator_status(logic [1:0] fn, logic [2:0] pr,
                                                    logic [7:0] amt [NTYPE]);
        if (fn == FUNC_CHECK)
            return (overcommitted() || !state_is_safe()) ? ST_UNSAFE : ST_OK;
        if (fn == FUNC_LOAD_MAX) begin
            for (int t = 0; t < NTYPE; t++)
                if (amt[t] < held_tab[pr][t]) return ST_REFUSED;
            for (int t = 0; t < NTYPE; t++) claim_tab[pr][t] = amt[t];
            return ST_OK;
        end
        if (fn == FUNC_LOAD_ALLOC) begin
            for (int t = 0; t < NTYPE; t++)
                if (amt[t] > claim_tab[pr][t]) return ST_REFUSED;
            for (int t = 0; t < NTYPE; t++) begin
                held_sum[t] = held_sum[t] - held_tab[pr][t] + amt[t];
                held_tab[pr][t] = amt[t];
            end
            return ST_OK;
        end
        for (int t = 0; t < NTYPE; t++)
            if (amt[t] > claim_tab[pr][t] - held_tab[pr][t]) return ST_EXCEEDS;
        if (overcommitted()) return ST_UNSAFE;
        for (int t = 0; t < NTYPE; t++)
            if ({3'b0, amt[t]} > {3'b0, total_units[t]} - held_sum[t]) return ST_WAIT;
        for (int t = 0; t < NTYPE; t++) begin
            held_tab[pr][t] += amt[t];
            held_sum[t] += amt[t];
        end
        if (state_is_safe()) return ST_OK;
        for (int t = 0; t < NTYPE; t++) begin
            held_tab[pr][t] -= amt[t];
            held_sum[t] -= amt[t];
        end
        return ST_ROLLBACK;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (status_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status=%0d", o_status);
            end else begin
                if (o_status !== status_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status mismatch: expected %0d actual %0d",
                                 status_queue[0], o_status);
                end
                void'(status_queue.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // one command transfer with random gap before it
    task automatic send_cmd(logic [1:0] fn, logic [2:0] pr, logic [7:0] a0,
                            logic [7:0] a1, logic [7:0] a2, logic [7:0] a3);
        logic [7:0] amt [NTYPE];
        logic [2:0] exp_st;
        int gap;
        amt[0] = a0; amt[1] = a1; amt[2] = a2; amt[3] = a3;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            idle_cycles(gap);
        end
        start <= 1'b1;
        i_func <= fn; i_process <= pr;
        i_amount0 <= a0; i_amount1 <= a1; i_amount2 <= a2; i_amount3 <= a3;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_st = allocator_status(fn, pr, amt);
        status_queue = {status_queue, exp_st};
    endtask

    task automatic drain();
        if (start) start <= 1'b0;
        while (status_queue.size() != 0) @(posedge i_clk);
        idle_cycles(10);
    endtask

    // register write, only while idle
    task automatic write_total(int idx, logic [7:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[2:0];
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        total_units[idx] = val;
    endtask

    task automatic set_totals(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                              logic [7:0] a3);
        write_total(0, a0);
        write_total(1, a1);
        write_total(2, a2);
        write_total(3, a3);
    endtask

    task automatic test_directed();
        // zero totals, all-zero tables are safe
        send_cmd(FUNC_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_LOAD_ALLOC, 3'd1, 8'd1, 8'd0, 8'd0, 8'd0);
        set_totals(8'd255, 8'd255, 8'd255, 8'd255);
        send_cmd(FUNC_LOAD_MAX, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255);
        send_cmd(FUNC_LOAD_ALLOC, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255);
        send_cmd(FUNC_LOAD_MAX, 3'd7, 8'd254, 8'd255, 8'd255, 8'd255);
        send_cmd(FUNC_CHECK, 3'd5, 8'd0, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_LOAD_MAX, 3'd0, 8'd10, 8'd10, 8'd10, 8'd10);
        send_cmd(FUNC_LOAD_ALLOC, 3'd0, 8'd1, 8'd0, 8'd0, 8'd0);
        // over-allocated: check unsafe, passing request answers unsafe
        send_cmd(FUNC_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_REQUEST, 3'd0, 8'd1, 8'd1, 8'd1, 8'd1);
        send_cmd(FUNC_REQUEST, 3'd0, 8'd10, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_LOAD_ALLOC, 3'd7, 8'd0, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_LOAD_ALLOC, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        set_totals(8'd12, 8'd6, 8'd4, 8'd3);
        send_cmd(FUNC_LOAD_MAX, 3'd1, 8'd10, 8'd5, 8'd4, 8'd3);
        send_cmd(FUNC_LOAD_MAX, 3'd7, 8'd0, 8'd0, 8'd0, 8'd0);
        // grants that leave the state unsafe and roll back, then a request beyond the claim
        send_cmd(FUNC_REQUEST, 3'd1, 8'd10, 8'd5, 8'd4, 8'd3);
        send_cmd(FUNC_REQUEST, 3'd0, 8'd5, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_REQUEST, 3'd1, 8'd5, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_REQUEST, 3'd0, 8'd2, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_REQUEST, 3'd0, 8'd13, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        drain();
    endtask

    // random amount biased toward small values, full range sometimes
    function automatic logic [7:0] rand_amt(int span);
        return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, span));
    endfunction

    task automatic test_random(int items);
        logic [1:0] fn;
        int span;
        for (int i = 0; i < items; i++) begin
            if (i % 250 == 0) begin
                span = (i / 250) % 2 ? 8 : 40;
                set_totals(8'($urandom_range(0, 2 * span)), 8'($urandom_range(0, 2 * span)),
                           8'($urandom_range(0, 2 * span)), 8'($urandom_range(0, 2 * span)));
            end
            case ($urandom_range(0, 9)) inside
                0, 1:    fn = FUNC_LOAD_MAX;
                2:       fn = FUNC_LOAD_ALLOC;
                3:       fn = FUNC_CHECK;
                default: fn = FUNC_REQUEST;
            endcase
            if (fn == FUNC_REQUEST)
                send_cmd(fn, 3'($urandom), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                         8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
            else
                send_cmd(fn, 3'($urandom), rand_amt(span), rand_amt(span),
                         rand_amt(span), rand_amt(span));
        end
        drain();
        // extremes of the totals at the end
        set_totals(8'd0, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        set_totals(8'd255, 8'd255, 8'd255, 8'd255);
        send_cmd(FUNC_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    endtask

    initial begin
        for (int t = 0; t < NTYPE; t++) begin
            total_units[t] = '0;
            held_sum[t] = '0;
            for (int p = 0; p < NPROC; p++) begin
                claim_tab[p][t] = '0;
                held_tab[p][t] = '0;
            end
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1000);
        drain();
        idle_cycles(200);
        if (mismatches == 0 && status_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
